// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// oaht_pkg
// Types and constants shared by the open addressing hash table modules.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int KEY_W    = 31;
    localparam int SIZE_W   = 5;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int MODE_W   = 2;
    localparam int MAX_SIZE = 31;   // largest size the size register can name

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

    localparam logic REG_PROBE_MODE = 1'b0;
    localparam logic REG_TABLE_SIZE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_LINEAR;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
    localparam logic [SIZE_W-1:0] MIN_SIZE   = 5'd2;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key;
    } in_word_t;

    typedef struct packed {
        logic             success;
        logic [IDX_W-1:0] slot_index;
        logic [CNT_W-1:0] probe_count;
    } out_word_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic advance;
        logic finish;
        logic success;
        logic write;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
        logic slot_valid;
        logic key_match;
        logic is_search;
        logic last_probe;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/open_addressing_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// open_addressing_hash_table_unit
// Open addressing hash table: insert or search one key per word, probing
// linearly, quadratically or by double hashing under a mode register.
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+---------------------------
//   in      | input     | in_valid/in_ready   | in_data  (opcode, key)
//   out     | output    | out_valid/out_ready | out_data (success, slot,
//           |           |                     |           probe count)
//   cfg     | input     | APB psel/penable    | probe_mode, table_size
//
// A word makes between one probe and one probe per slot in use. The serial
// remainder unit takes the key one bit at a time; every probe is a registered
// key RAM read followed by its check.
// Reset empties the table at once through per-slot valid flops; no sweep.
// A finished word waits in the output register while the next word is taken;
// a second result waits inside until that register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module open_addressing_hash_table_unit #(
    parameter int SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  oaht_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output oaht_pkg::out_word_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import oaht_pkg::*;

    logic [MODE_W-1:0] probe_mode_reg;
    logic [SIZE_W-1:0] table_size_reg;
    logic              cfg_write;
    logic              reg_sel;
    dp_cmd_t           cmd;
    dp_status_t        status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_mode_reg <= MODE_RESET;
            table_size_reg <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_PROBE_MODE: probe_mode_reg <= pwdata[MODE_W-1:0];
                REG_TABLE_SIZE: table_size_reg <= pwdata[SIZE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_PROBE_MODE: prdata = 32'(probe_mode_reg);
            REG_TABLE_SIZE: prdata = 32'(table_size_reg);
            default:        prdata = '0;
        endcase
    end

    oaht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    oaht_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (in_data),
        .probe_mode (probe_mode_reg),
        .table_size (table_size_reg),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // a taken word keeps the input closed until its result is handed off
    `ASSERT_CLK(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready after accept")
    `ASSERT_CLK(a_result_from_busy, $rose(out_valid) |-> !$past(in_ready), "result while idle")
    `ASSERT_NEVER(a_zero_probes, out_valid && out_data.probe_count == '0, "zero probe count")

endmodule

// ===== src/oaht_ram.sv =====
// ----------------------------------------------------------------------------
// oaht_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module oaht_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/oaht_ctrl.sv =====
// ----------------------------------------------------------------------------
// oaht_ctrl
// Sequencer: remainder steps, probe read/check loop, result hand-off.
// ----------------------------------------------------------------------------
module oaht_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  oaht_pkg::dp_status_t status,
    output oaht_pkg::dp_cmd_t    cmd
);
    import oaht_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_READ  = 5'b00100,
        S_CHECK = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   hit;
    logic   stop;

    always_comb
    begin
        hit  = status.is_search ? (status.slot_valid && status.key_match) : !status.slot_valid;
        stop = hit || (status.is_search && !status.slot_valid) || status.last_probe;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.finish  = stop;
                cmd.success = hit;
                cmd.write   = hit && !status.is_search;
                cmd.advance = !stop;
                state_next  = stop ? S_DONE : S_READ;
            end
            S_DONE:
            begin
                cmd.publish = status.out_free;
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/oaht_dp.sv =====
// ----------------------------------------------------------------------------
// oaht_dp
// Datapath: serial remainder unit, probe position walk, slot store, result.
// ----------------------------------------------------------------------------
module oaht_dp #(
    parameter int SLOTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  oaht_pkg::in_word_t             in_data,
    input  logic [oaht_pkg::MODE_W-1:0]    probe_mode,
    input  logic [oaht_pkg::SIZE_W-1:0]    table_size,
    input  oaht_pkg::dp_cmd_t              cmd,
    output oaht_pkg::dp_status_t           status,
    output logic                           out_valid,
    input  logic                           out_ready,
    output oaht_pkg::out_word_t            out_data
);
    import oaht_pkg::*;

    // Only slots below the largest programmable size are ever reached.
    localparam int USED = (SLOTS > MAX_SIZE) ? MAX_SIZE : SLOTS;
    localparam int AW   = $clog2(USED);
    localparam logic [SIZE_W-1:0] USED_N = SIZE_W'(USED);
    localparam logic [SIZE_W-1:0] LAST_BIT = SIZE_W'(KEY_W - 1);

    logic [SIZE_W-1:0] n;
    logic [SIZE_W-1:0] n_m1;

    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  shift_reg;
    logic [SIZE_W-1:0] div_cnt_reg;
    logic [SIZE_W-1:0] r1_reg, r1_next;
    logic [SIZE_W-1:0] r2_reg, r2_next;
    logic [SIZE_W-1:0] pos_reg;
    logic [SIZE_W-1:0] delta_reg;
    logic [CNT_W-1:0]  probe_idx_reg;
    logic [SIZE_W:0]   t1, t2, pos_sum, delta_sum;
    logic [SIZE_W-1:0] pos_step, delta_step;
    logic              res_ok_reg;
    logic [IDX_W-1:0]  res_slot_reg;
    logic [CNT_W-1:0]  res_cnt_reg;
    logic              out_valid_reg;
    out_word_t         out_reg;
    logic [USED-1:0]   valid_reg;
    logic [AW-1:0]     slot_addr;
    logic [KEY_W-1:0]  ram_rdata;

    always_comb
    begin
        if (table_size < MIN_SIZE)
        begin
            n = MIN_SIZE;
        end
        else if (table_size > USED_N)
        begin
            n = USED_N;
        end
        else
        begin
            n = table_size;
        end
        n_m1 = n - SIZE_W'(1);
    end

    // one key bit per cycle into both remainders: key mod n, key mod (n-1)
    always_comb
    begin
        t1 = {r1_reg, shift_reg[KEY_W-1]};
        t2 = {r2_reg, shift_reg[KEY_W-1]};
        r1_next = (t1 >= {1'b0, n})    ? SIZE_W'(t1 - {1'b0, n})    : SIZE_W'(t1);
        r2_next = (t2 >= {1'b0, n_m1}) ? SIZE_W'(t2 - {1'b0, n_m1}) : SIZE_W'(t2);
    end

    // next probe position and the quadratic increment, both kept below n
    always_comb
    begin
        pos_sum    = {1'b0, pos_reg} + {1'b0, delta_reg};
        pos_step   = (pos_sum >= {1'b0, n}) ? SIZE_W'(pos_sum - {1'b0, n}) : SIZE_W'(pos_sum);
        delta_sum  = {1'b0, delta_reg} + (SIZE_W + 1)'(2);
        delta_step = (delta_sum >= {1'b0, n}) ? SIZE_W'(delta_sum - {1'b0, n})
                                               : SIZE_W'(delta_sum);
    end

    assign slot_addr = pos_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg        <= in_data.opcode;
            key_reg       <= in_data.key;
            shift_reg     <= in_data.key;
            div_cnt_reg   <= '0;
            r1_reg        <= '0;
            r2_reg        <= '0;
            probe_idx_reg <= '0;
        end
        if (cmd.div_step)
        begin
            shift_reg   <= {shift_reg[KEY_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + SIZE_W'(1);
            r1_reg      <= r1_next;
            r2_reg      <= r2_next;
            if (status.div_last)
            begin
                pos_reg <= r1_next;
                if (probe_mode == MODE_LINEAR || probe_mode == MODE_QUAD)
                begin
                    delta_reg <= SIZE_W'(1);
                end
                else
                begin
                    delta_reg <= r2_next + SIZE_W'(1);
                end
            end
        end
        if (cmd.advance)
        begin
            pos_reg       <= pos_step;
            probe_idx_reg <= probe_idx_reg + CNT_W'(1);
            if (probe_mode == MODE_QUAD)
            begin
                delta_reg <= delta_step;
            end
        end
        if (cmd.finish)
        begin
            res_ok_reg   <= cmd.success;
            res_slot_reg <= cmd.success ? pos_reg[IDX_W-1:0] : '0;
            res_cnt_reg  <= probe_idx_reg + CNT_W'(1);
        end
        if (cmd.publish)
        begin
            out_reg.success     <= res_ok_reg;
            out_reg.slot_index  <= res_slot_reg;
            out_reg.probe_count <= res_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                valid_reg[slot_addr] <= 1'b1;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    oaht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (USED)
    ) u_key_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (slot_addr),
        .wdata (key_reg),
        .raddr (slot_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        status.div_last   = (div_cnt_reg == LAST_BIT);
        status.slot_valid = valid_reg[slot_addr];
        status.key_match  = (ram_rdata == key_reg);
        status.is_search  = (op_reg == OP_SEARCH);
        status.last_probe = (probe_idx_reg == CNT_W'(n_m1));
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
